FILE: rtl/bsa_pkg.sv
package bsa_pkg;

  localparam int WORD_BITS = 64;
  localparam int MAX_WORDS = 64;

  localparam int WORD_AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int BIT_AW  = $clog2(WORD_BITS);
  localparam int CNT_W   = $clog2(MAX_WORDS + 1);

  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 12;
  localparam int WIU_W   = 7;
  localparam int SIZE_W  = 16;
  localparam int ADDR_W  = 32;
  localparam int PROD_W  = SLOT_W + SIZE_W;
  localparam int CIDX_W  = 2;
  localparam int CDAT_W  = 32;
  localparam int CMP_W   = (WIU_W > CNT_W) ? WIU_W : CNT_W;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WORD_AW-1:0]   waddr_t;
  typedef logic [BIT_AW-1:0]    bitidx_t;
  typedef logic [CNT_W-1:0]     wcnt_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_WORDS_IN_USE = 2'd0,
    REG_SLOT_SIZE    = 2'd1,
    REG_POOL_BASE    = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC_RD,
    ST_ALLOC_CHK,
    ST_MUL,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [WIU_W-1:0]  words_in_use;
    logic [SIZE_W-1:0] slot_size;
    logic [ADDR_W-1:0] pool_base;
  } cfg_t;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] slot_number;
    logic [ADDR_W-1:0] slot_address;
    logic              bad_free;
  } res_t;

  typedef struct packed {
    logic    found;
    bitidx_t idx;
  } clear_bit_t;

  // lowest clear bit of an occupancy word
  function automatic clear_bit_t lowest_clear(input word_t w);
    clear_bit_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!w[b]) begin
        r.found = 1'b1;
        r.idx   = BIT_AW'(b);
      end
    end
    return r;
  endfunction

  // words in use, clamped to 1..MAX_WORDS
  function automatic wcnt_t active_words(input logic [WIU_W-1:0] wiu);
    logic [CMP_W-1:0] v;
    v = CMP_W'(wiu);
    if (v == '0) begin
      return CNT_W'(1);
    end else if (v > CMP_W'(MAX_WORDS)) begin
      return CNT_W'(MAX_WORDS);
    end else begin
      return CNT_W'(v);
    end
  endfunction

endpackage

FILE: rtl/bsa_in_if.sv
interface bsa_in_if;
  import bsa_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SLOT_W-1:0]   slot_index;

  modport source (output valid, kind, slot_index, input ready);
  modport sink   (input valid, kind, slot_index, output ready);
endinterface

FILE: rtl/bsa_out_if.sv
interface bsa_out_if;
  import bsa_pkg::*;
  logic                valid;
  logic                ready;
  logic                granted;
  logic [SLOT_W-1:0]   slot_number;
  logic [ADDR_W-1:0]   slot_address;
  logic                bad_free;

  modport source (output valid, granted, slot_number, slot_address, bad_free,
                  input ready);
  modport sink   (input valid, granted, slot_number, slot_address, bad_free,
                  output ready);
endinterface

FILE: rtl/bsa_cfg_if.sv
interface bsa_cfg_if;
  import bsa_pkg::*;
  logic                valid;
  logic                ready;
  logic [CIDX_W-1:0]   reg_index;
  logic [CDAT_W-1:0]   wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

FILE: rtl/bsa_ram.sv
module bsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/bsa_ctrl.sv
module bsa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  bsa_in_if.sink           in_ch,
  input  bsa_pkg::cfg_t    cfg,
  output logic             res_valid,
  input  logic             res_ready,
  output bsa_pkg::res_t    res,
  output logic             ram_we,
  output bsa_pkg::waddr_t  ram_waddr,
  output bsa_pkg::word_t   ram_wdata,
  output bsa_pkg::waddr_t  ram_raddr,
  input  bsa_pkg::word_t   ram_rdata
);
  import bsa_pkg::*;

  state_t             state_r, state_nxt;
  logic [SLOT_W-1:0]  idx_r, idx_nxt;
  waddr_t             w_r, w_nxt;
  wcnt_t              cnt_r, cnt_nxt;
  waddr_t             hint_r, hint_nxt;
  logic [MAX_WORDS-1:0] wvalid_r, wvalid_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic               granted_r, granted_nxt;
  logic               bad_r, bad_nxt;

  wcnt_t      words;
  word_t      cur_word;
  clear_bit_t lc;
  waddr_t     start_w;
  waddr_t     free_w;
  bitidx_t    free_b;
  logic       free_bad;
  wcnt_t      cnt_inc;
  logic       last_w;
  logic       accept;

  assign words    = active_words(cfg.words_in_use);
  // entries never written since reset or clear read as empty
  assign cur_word = wvalid_r[w_r] ? ram_rdata : '0;
  assign lc       = lowest_clear(cur_word);
  assign start_w  = (CNT_W'(hint_r) < words) ? hint_r : '0;
  assign free_w   = WORD_AW'(in_ch.slot_index >> BIT_AW);
  assign free_b   = idx_r[BIT_AW-1:0];
  assign free_bad = 32'(in_ch.slot_index) >= (32'(words) << BIT_AW);
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign last_w   = (CNT_W'(w_r) + CNT_W'(1)) == words;
  assign accept   = in_ch.valid && in_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          unique case (kind_t'(in_ch.kind))
            KIND_ALLOC: state_nxt = ST_ALLOC_RD;
            KIND_FREE:  state_nxt = free_bad ? ST_RESP : ST_FREE_RD;
            KIND_CLEAR: state_nxt = ST_RESP;
            KIND_NOP:   state_nxt = ST_RESP;
            default:    state_nxt = ST_RESP;
          endcase
        end
      end
      ST_ALLOC_RD: state_nxt = ST_ALLOC_CHK;
      ST_ALLOC_CHK: begin
        if (lc.found) begin
          state_nxt = ST_MUL;
        end else if (cnt_inc == words) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_ALLOC_RD;
        end
      end
      ST_MUL:     state_nxt = ST_RESP;
      ST_FREE_RD: state_nxt = ST_FREE_WR;
      ST_FREE_WR: state_nxt = ST_RESP;
      ST_RESP:    state_nxt = res_ready ? ST_IDLE : ST_RESP;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = 1'b0;
    res_valid   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = w_r;
    ram_wdata   = '0;
    ram_raddr   = w_r;
    unique case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_ALLOC_RD: ram_raddr = w_r;
      ST_ALLOC_CHK: begin
        ram_we    = lc.found;
        ram_wdata = cur_word | (word_t'(1) << lc.idx);
      end
      ST_MUL: ram_raddr = w_r;
      ST_FREE_RD: ram_raddr = w_r;
      ST_FREE_WR: begin
        ram_we    = 1'b1;
        ram_wdata = cur_word & ~(word_t'(1) << free_b);
      end
      ST_RESP: res_valid = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  always_comb begin
    res.granted      = granted_r;
    res.slot_number  = granted_r ? slot_r : '0;
    res.slot_address = granted_r ? (cfg.pool_base + ADDR_W'(prod_r)) : '0;
    res.bad_free     = bad_r;
  end

  // datapath registers
  always_comb begin
    idx_nxt     = idx_r;
    w_nxt       = w_r;
    cnt_nxt     = cnt_r;
    hint_nxt    = hint_r;
    wvalid_nxt  = wvalid_r;
    slot_nxt    = slot_r;
    prod_nxt    = prod_r;
    granted_nxt = granted_r;
    bad_nxt     = bad_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt     = in_ch.slot_index;
          granted_nxt = 1'b0;
          bad_nxt     = 1'b0;
          cnt_nxt     = '0;
          unique case (kind_t'(in_ch.kind))
            KIND_ALLOC: w_nxt = start_w;
            KIND_FREE: begin
              bad_nxt = free_bad;
              w_nxt   = free_w;
            end
            KIND_CLEAR: begin
              for (int i = 0; i < MAX_WORDS; i++) begin
                if (CNT_W'(i) < words) begin
                  wvalid_nxt[i] = 1'b0;
                end
              end
            end
            KIND_NOP: bad_nxt = 1'b0;
            default:  bad_nxt = 1'b0;
          endcase
        end
      end
      ST_ALLOC_CHK: begin
        if (lc.found) begin
          wvalid_nxt[w_r] = 1'b1;
          hint_nxt        = w_r;
          granted_nxt     = 1'b1;
          slot_nxt        = SLOT_W'({w_r, lc.idx});
        end else begin
          cnt_nxt = cnt_inc;
          w_nxt   = last_w ? '0 : w_r + WORD_AW'(1);
        end
      end
      ST_MUL:     prod_nxt = PROD_W'(slot_r) * PROD_W'(cfg.slot_size);
      ST_FREE_WR: wvalid_nxt[w_r] = 1'b1;
      default:    prod_nxt = prod_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      hint_r    <= '0;
      wvalid_r  <= '0;
      granted_r <= 1'b0;
      bad_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      hint_r    <= hint_nxt;
      wvalid_r  <= wvalid_nxt;
      granted_r <= granted_nxt;
      bad_r     <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    w_r    <= w_nxt;
    cnt_r  <= cnt_nxt;
    slot_r <= slot_nxt;
    prod_r <= prod_nxt;
  end

endmodule

FILE: rtl/bitmap_slot_allocator.sv
// Bitmap slot allocator, next-fit search over 64-bit occupancy words.
// in_ch carries one item per handshake: kind (allocate, free, clear all)
// and slot_index for a free. out_ch returns exactly one item per input
// item, in order: granted, slot_number, slot_address, bad_free.
// cfg_ch writes words_in_use (index 0), slot_size (1) and pool_base (2);
// write only while no item is in flight. cfg_ch.ready is always high.
// One item is processed at a time. Steps from accept to out valid:
//   allocate: each word scanned (1 up to words_in_use) takes a RAM read
//     state and a check/write-back state; with a grant a multiply state
//     for the address follows, then the respond state; when the pool is
//     full the scan goes straight to the respond state.
//   free: read, write back, respond; out-of-range free: respond only.
//   clear, unused kind: respond only (per-word valid bits dropped at once).
// in_ch.ready is high only while idle, so the next item can follow in the cycle
// after its result is loaded. The result register holds a waiting item
// while the next one is taken; a stalled receiver stalls the block only
// when a second result is ready.
// Synchronous reset empties the bitmap and the hint, sets words_in_use 1,
// slot_size 1, pool_base 0, and drops any pending result.
module bitmap_slot_allocator (
  input  logic     clk,
  input  logic     rst_n,
  bsa_in_if.sink   in_ch,
  bsa_out_if.source out_ch,
  bsa_cfg_if.sink  cfg_ch
);
  import bsa_pkg::*;

  cfg_t   cfg_r;
  logic   out_valid_r;
  res_t   out_r;
  logic   res_valid;
  logic   res_ready;
  res_t   res;
  logic   ram_we;
  waddr_t ram_waddr;
  word_t  ram_wdata;
  waddr_t ram_raddr;
  word_t  ram_rdata;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.words_in_use <= WIU_W'(1);
      cfg_r.slot_size    <= SIZE_W'(1);
      cfg_r.pool_base    <= '0;
    end else if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.reg_index))
        REG_WORDS_IN_USE: cfg_r.words_in_use <= cfg_ch.wdata[WIU_W-1:0];
        REG_SLOT_SIZE:    cfg_r.slot_size    <= cfg_ch.wdata[SIZE_W-1:0];
        REG_POOL_BASE:    cfg_r.pool_base    <= cfg_ch.wdata[ADDR_W-1:0];
        REG_UNUSED:       cfg_r              <= cfg_r;
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.granted      = out_r.granted;
  assign out_ch.slot_number  = out_r.slot_number;
  assign out_ch.slot_address = out_r.slot_address;
  assign out_ch.bad_free     = out_r.bad_free;

  bsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  bsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAX_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: rtl/bsa_checker.sv
module bsa_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_granted,
  input logic [bsa_pkg::SLOT_W-1:0] out_slot_number,
  input logic [bsa_pkg::ADDR_W-1:0] out_slot_address,
  input logic                      out_bad_free
);
  import bsa_pkg::*;

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");

  a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> out_slot_number == '0 && out_slot_address == '0)
    else $error("slot fields nonzero without a grant");

  a_grant_xor_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_granted && out_bad_free))
    else $error("grant and bad free together");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_granted      (out_ch.granted),
  .out_slot_number  (out_ch.slot_number),
  .out_slot_address (out_ch.slot_address),
  .out_bad_free     (out_ch.bad_free)
);

FILE: sim/tb_bitmap_slot_allocator.sv
module tb_bitmap_slot_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import bsa_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int N_DIRECTED  = 15;
  localparam int SETTLE_WAIT = 140;  // longest allocate scan plus margin

  typedef struct {
    kind_t             kind;
    logic [SLOT_W-1:0] index;
    bit                typed;
    res_t              want;
  } op_row_t;

  logic clk;
  logic rst_n;

  bsa_in_if  in_ch ();
  bsa_out_if out_ch ();
  bsa_cfg_if cfg_ch ();

  bitmap_slot_allocator i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // allocator shadow state
  word_t             slot_map [MAX_WORDS];
  waddr_t            last_hit_word;
  logic [WIU_W-1:0]  words_cfg;
  logic [SIZE_W-1:0] size_cfg;
  logic [ADDR_W-1:0] base_cfg;

  res_t expected_results[$];

  int error_count;
  int ops_sent;
  int results_seen;
  int grants;
  int full_refusals;
  int bad_frees;
  int send_gap_pct;
  int recv_stall_pct;
  int recv_hold_cycles;
  int quiet_cycles;

  // reset config: words_in_use 1, slot_size 1, pool_base 0
  op_row_t directed_ops [N_DIRECTED] = '{
    '{KIND_ALLOC, 12'd0,    1'b1, '{1'b1, 12'd0, 32'd0, 1'b0}},
    '{KIND_ALLOC, 12'hFFF,  1'b1, '{1'b1, 12'd1, 32'd1, 1'b0}},
    '{KIND_ALLOC, 12'd0,    1'b1, '{1'b1, 12'd2, 32'd2, 1'b0}},
    '{KIND_FREE,  12'd1,    1'b1, '{1'b0, 12'd0, 32'd0, 1'b0}},
    '{KIND_FREE,  12'd1,    1'b1, '{1'b0, 12'd0, 32'd0, 1'b0}},
    '{KIND_ALLOC, 12'h555,  1'b1, '{1'b1, 12'd1, 32'd1, 1'b0}},
    '{KIND_FREE,  12'd64,   1'b1, '{1'b0, 12'd0, 32'd0, 1'b1}},
    '{KIND_FREE,  12'hFFF,  1'b1, '{1'b0, 12'd0, 32'd0, 1'b1}},
    '{KIND_FREE,  12'd63,   1'b1, '{1'b0, 12'd0, 32'd0, 1'b0}},
    '{KIND_NOP,   12'hAAA,  1'b1, '{1'b0, 12'd0, 32'd0, 1'b0}},
    '{KIND_NOP,   12'h555,  1'b1, '{1'b0, 12'd0, 32'd0, 1'b0}},
    '{KIND_CLEAR, 12'hFFF,  1'b1, '{1'b0, 12'd0, 32'd0, 1'b0}},
    '{KIND_ALLOC, 12'd0,    1'b1, '{1'b1, 12'd0, 32'd0, 1'b0}},
    '{KIND_ALLOC, 12'hAAA,  1'b0, '0},
    '{KIND_CLEAR, 12'd0,    1'b1, '{1'b0, 12'd0, 32'd0, 1'b0}}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 40) begin
      $display("ERROR: %s", msg);
    end
  endtask

  function automatic int unsigned pool_words();
    if (words_cfg == '0) begin
      return 1;
    end
    if (words_cfg > MAX_WORDS) begin
      return MAX_WORDS;
    end
    return words_cfg;
  endfunction

  function automatic res_t apply_op(input kind_t kind, input logic [SLOT_W-1:0] index);
    res_t        r;
    int unsigned n;
    int unsigned w;
    bit          found;
    r     = '0;
    n     = pool_words();
    found = 1'b0;
    case (kind)
      KIND_ALLOC: begin
        // stale hint restarts at word 0
        w = (last_hit_word < n) ? last_hit_word : 0;
        for (int i = 0; i < n && !found; i++) begin
          for (int b = 0; b < WORD_BITS && !found; b++) begin
            if (!slot_map[w][b]) begin
              slot_map[w][b] = 1'b1;
              last_hit_word  = waddr_t'(w);
              r.granted      = 1'b1;
              r.slot_number  = SLOT_W'(w * WORD_BITS + b);
              r.slot_address = base_cfg + ADDR_W'(r.slot_number) * ADDR_W'(size_cfg);
              found          = 1'b1;
            end
          end
          if (!found) begin
            w = (w + 1 >= n) ? 0 : w + 1;
          end
        end
        if (found) begin
          grants++;
        end else begin
          full_refusals++;
        end
      end
      KIND_FREE: begin
        if (index >= n * WORD_BITS) begin
          r.bad_free = 1'b1;
          bad_frees++;
        end else begin
          slot_map[index / WORD_BITS][index % WORD_BITS] = 1'b0;
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < n; i++) begin
          slot_map[i] = '0;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic offer_op(input kind_t kind, input logic [SLOT_W-1:0] index,
                          input bit typed, input res_t want);
    res_t predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.slot_index <= index;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = apply_op(kind, index);
    expected_results.push_back(typed ? want : predicted);
    ops_sent++;
  endtask

  task automatic run_random(input int count, input int alloc_pct, input int free_pct,
                            input int clear_pct);
    kind_t             kind;
    logic [SLOT_W-1:0] index;
    int unsigned       pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < alloc_pct) begin
        kind = KIND_ALLOC;
      end else if (pick < alloc_pct + free_pct) begin
        kind = KIND_FREE;
      end else if (pick < alloc_pct + free_pct + clear_pct) begin
        kind = KIND_CLEAR;
      end else begin
        kind = KIND_NOP;
      end
      // frees mostly land inside the pool so slots get recycled
      if (kind == KIND_FREE && $urandom_range(3) != 0) begin
        index = SLOT_W'($urandom_range(pool_words() * WORD_BITS - 1));
      end else begin
        index = SLOT_W'($urandom_range(4095));
      end
      offer_op(kind, index, 1'b0, '0);
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input reg_idx_t r, input logic [CDAT_W-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= r;
    cfg_ch.wdata     <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (r)
      REG_WORDS_IN_USE: words_cfg = data[WIU_W-1:0];
      REG_SLOT_SIZE:    size_cfg  = data[SIZE_W-1:0];
      REG_POOL_BASE:    base_cfg  = data;
      default: begin
      end
    endcase
  endtask

  // upper bits carry junk: the block keeps only the register's width
  task automatic write_regs(input logic [WIU_W-1:0] words, input logic [SIZE_W-1:0] size,
                            input logic [ADDR_W-1:0] base, input bit poke_unused);
    put_reg(REG_WORDS_IN_USE, {25'($urandom()), words});
    put_reg(REG_SLOT_SIZE, {16'($urandom()), size});
    put_reg(REG_POOL_BASE, base);
    if (poke_unused) begin
      put_reg(REG_UNUSED, $urandom());
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // result side: checks against the oldest pending expectation
  initial begin
    res_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_error($sformatf("result %0d arrived with nothing pending", results_seen));
        end else begin
          want = expected_results.pop_front();
          if (out_ch.granted !== want.granted || out_ch.slot_number !== want.slot_number ||
              out_ch.slot_address !== want.slot_address || out_ch.bad_free !== want.bad_free)
          begin
            report_error($sformatf(
              "result %0d: got g=%b n=%0d a=%h bf=%b, want g=%b n=%0d a=%h bf=%b",
              results_seen, out_ch.granted, out_ch.slot_number, out_ch.slot_address,
              out_ch.bad_free, want.granted, want.slot_number, want.slot_address,
              want.bad_free));
          end
        end
      end
      if (recv_hold_cycles > 0) begin
        recv_hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
        (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results pending",
               quiet_cycles, expected_results.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < MAX_WORDS; i++) begin
      slot_map[i] = '0;
    end
    last_hit_word    = '0;
    words_cfg        = WIU_W'(1);
    size_cfg         = SIZE_W'(1);
    base_cfg         = '0;
    error_count      = 0;
    ops_sent         = 0;
    results_seen     = 0;
    grants           = 0;
    full_refusals    = 0;
    bad_frees        = 0;
    send_gap_pct     = 0;
    recv_stall_pct   = 0;
    recv_hold_cycles = 0;
    quiet_cycles     = 0;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= KIND_ALLOC;
    in_ch.slot_index <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= REG_WORDS_IN_USE;
    cfg_ch.wdata     <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      offer_op(directed_ops[i].kind, directed_ops[i].index, directed_ops[i].typed,
               directed_ops[i].want);
    end
    in_ch.valid <= 1'b0;
    wait_idle();

    // two words, allocate only: word 0 fills, hint moves to word 1
    write_regs(WIU_W'(2), 16'hFFFF, 32'hFFFF_FFF0, 1'b0);
    run_random(70, 100, 0, 0);
    wait_idle();

    // zero words acts as one: hint is stale and word 0 is full
    send_gap_pct = 61;
    write_regs('0, '0, $urandom(), 1'b0);
    run_random(60, 60, 30, 5);
    wait_idle();

    // above the maximum clamps to all words; addresses wrap
    send_gap_pct   = 0;
    recv_stall_pct = 61;
    write_regs(WIU_W'(127), 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    run_random(120, 60, 30, 5);
    wait_idle();

    send_gap_pct   = 8;
    recv_stall_pct = 8;
    write_regs(WIU_W'(MAX_WORDS), SIZE_W'($urandom_range(2, 65534)), $urandom(), 1'b0);
    run_random(130, 55, 35, 5);
    wait_idle();

    // receiver holds off while items keep coming, so the input backs up
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    write_regs(WIU_W'(3), SIZE_W'(1), '0, 1'b1);
    recv_hold_cycles = 300;
    run_random(60, 70, 25, 3);

    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_error($sformatf("%0d results never arrived", expected_results.size()));
    end

    $display("Ran %0d items through six pool setups (1 to 64 words, clamped sizes,", ops_sent);
    $display("wrapping addresses): %0d grants, %0d full-pool refusals, %0d bad frees, %0d errors",
             grants, full_refusals, bad_frees, error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
